[rtl/core/kmcr_pkg.sv]
// ----------------------------------------------------------------------------
// kmcr_pkg
// Shared types, widths and codes of the keypad matrix change reporter.
// ----------------------------------------------------------------------------
package kmcr_pkg;

  localparam int SNAP_W       = 64;
  localparam int ROW_BITS     = 3;
  localparam int SCAN_CODE_W  = 6;
  localparam int KEY_CODE_W   = 10;
  localparam int COUNT_W      = 4;
  localparam int SHIFT_W      = 2;

  localparam int DEF_MAX_COLUMNS  = 8;
  localparam int DEF_MAX_ROWS     = 8;
  localparam int DEF_KEYMAP_DEPTH = 64;

  localparam int APB_ADDR_W = 4;
  localparam int APB_DATA_W = 32;

  localparam logic CMD_SNAPSHOT  = 1'b0;
  localparam logic CMD_MAP_WRITE = 1'b1;

  localparam logic [1:0] REG_ROWS     = 2'd0;
  localparam logic [1:0] REG_COLUMNS  = 2'd1;
  localparam logic [1:0] REG_KEY_LOCK = 2'd2;

  localparam logic [COUNT_W-1:0] ROWS_RESET    = 4'd8;
  localparam logic [COUNT_W-1:0] COLUMNS_RESET = 4'd8;

  typedef struct packed {
    logic [COUNT_W-1:0] rows_in_use;
    logic [COUNT_W-1:0] columns_in_use;
    logic               key_lock;
  } kmcr_cfg_t;

  typedef struct packed {
    logic                   we;
    logic [SCAN_CODE_W-1:0] waddr;
    logic [KEY_CODE_W-1:0]  wdata;
    logic                   re;
    logic [SCAN_CODE_W-1:0] raddr;
  } kmcr_km_req_t;

  // ceil(log2(n)) for n up to 8, 3 above that; 0 and 1 give 0
  function automatic logic [SHIFT_W-1:0] order_of(input logic [COUNT_W-1:0] n);
    logic [SHIFT_W-1:0] s;
    if (n <= 4'd1) begin
      s = 2'd0;
    end else if (n <= 4'd2) begin
      s = 2'd1;
    end else if (n <= 4'd4) begin
      s = 2'd2;
    end else begin
      s = 2'd3;
    end
    return s;
  endfunction

endpackage

[rtl/core/kmcr_if.sv]
// ----------------------------------------------------------------------------
// kmcr_if
// Valid/ready channels: input items and reported events.
// ----------------------------------------------------------------------------
interface kmcr_in_if;
  logic                               valid;
  logic                               ready;
  logic                               cmd;
  logic [kmcr_pkg::SNAP_W-1:0]        matrix_snapshot;
  logic [kmcr_pkg::SCAN_CODE_W-1:0]   map_index;
  logic [kmcr_pkg::KEY_CODE_W-1:0]    map_keycode;

  modport source (output valid, cmd, matrix_snapshot, map_index, map_keycode,
                  input ready);
  modport sink   (input valid, cmd, matrix_snapshot, map_index, map_keycode,
                  output ready);
endinterface

interface kmcr_out_if;
  logic                               valid;
  logic                               ready;
  logic [kmcr_pkg::SCAN_CODE_W-1:0]   scan_code;
  logic [kmcr_pkg::KEY_CODE_W-1:0]    key_code;
  logic                               pressed;
  logic                               is_sync;
  logic                               last;

  modport source (output valid, scan_code, key_code, pressed, is_sync, last,
                  input ready);
  modport sink   (input valid, scan_code, key_code, pressed, is_sync, last,
                  output ready);
endinterface

[rtl/core/keypad_matrix_change_reporter.sv]
// ----------------------------------------------------------------------------
// keypad_matrix_change_reporter
// Reports key matrix changes as keymapped events, then a sync marker.
// ----------------------------------------------------------------------------
// items: valid/ready input. cmd selects a snapshot or a keymap entry write.
//   A keymap write gives no result.
// events: valid/ready output through one output register. Each snapshot
//   gives at most one event per column in use, then a sync transaction
//   with is_sync and last set.
// A snapshot is taken in, then the row/column positions in use are scanned,
//   each column up to its first event; a changed position with a keymap
//   lookup waits for the memory read, and the sync is loaded last. The next
//   item is taken after the sync has been loaded, while it still waits in
//   the output register.
// A stalled receiver holds the scan at the next event or sync until the
//   output register frees.
// Registers over APB: rows_in_use at 0x0, columns_in_use at 0x4,
//   key_lock at 0x8; write only while idle.
// Reset clears the stored snapshot and the keymap valid flags at once, so
//   every key reads as unmapped; no clearing pass is needed.
// ----------------------------------------------------------------------------
module keypad_matrix_change_reporter #(
  parameter int MAX_COLUMNS  = kmcr_pkg::DEF_MAX_COLUMNS,
  parameter int MAX_ROWS     = kmcr_pkg::DEF_MAX_ROWS,
  parameter int KEYMAP_DEPTH = kmcr_pkg::DEF_KEYMAP_DEPTH
) (
  input  logic                              clk,
  input  logic                              rst,
  kmcr_in_if.sink                           items,
  kmcr_out_if.source                        events,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [kmcr_pkg::APB_ADDR_W-1:0]   paddr,
  input  logic [kmcr_pkg::APB_DATA_W-1:0]   pwdata,
  output logic [kmcr_pkg::APB_DATA_W-1:0]   prdata,
  output logic                              pready
);

  kmcr_pkg::kmcr_cfg_t              cfg;
  kmcr_pkg::kmcr_km_req_t           km_req;
  logic [kmcr_pkg::KEY_CODE_W-1:0]  km_rdata;

  kmcr_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  kmcr_keymap #(
    .KEYMAP_DEPTH (KEYMAP_DEPTH)
  ) u_keymap (
    .clk   (clk),
    .rst   (rst),
    .req   (km_req),
    .rdata (km_rdata)
  );

  kmcr_scan #(
    .MAX_COLUMNS  (MAX_COLUMNS),
    .MAX_ROWS     (MAX_ROWS),
    .KEYMAP_DEPTH (KEYMAP_DEPTH)
  ) u_scan (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .items    (items),
    .events   (events),
    .km_req   (km_req),
    .km_rdata (km_rdata)
  );

endmodule

[rtl/core/kmcr_cfg.sv]
// ----------------------------------------------------------------------------
// kmcr_cfg
// APB register file: rows in use, columns in use, key lock.
// ----------------------------------------------------------------------------
module kmcr_cfg (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [kmcr_pkg::APB_ADDR_W-1:0]   paddr,
  input  logic [kmcr_pkg::APB_DATA_W-1:0]   pwdata,
  output logic [kmcr_pkg::APB_DATA_W-1:0]   prdata,
  output logic                              pready,
  output kmcr_pkg::kmcr_cfg_t               cfg
);

  logic       wr;
  logic [1:0] idx;

  assign pready = 1'b1;
  assign wr     = psel && penable && pwrite;
  assign idx    = paddr[3:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.rows_in_use    <= kmcr_pkg::ROWS_RESET;
      cfg.columns_in_use <= kmcr_pkg::COLUMNS_RESET;
      cfg.key_lock       <= 1'b0;
    end else if (wr) begin
      unique case (idx)
        kmcr_pkg::REG_ROWS:     cfg.rows_in_use    <= pwdata[3:0];
        kmcr_pkg::REG_COLUMNS:  cfg.columns_in_use <= pwdata[3:0];
        kmcr_pkg::REG_KEY_LOCK: cfg.key_lock       <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      kmcr_pkg::REG_ROWS:     prdata = kmcr_pkg::APB_DATA_W'(cfg.rows_in_use);
      kmcr_pkg::REG_COLUMNS:  prdata = kmcr_pkg::APB_DATA_W'(cfg.columns_in_use);
      kmcr_pkg::REG_KEY_LOCK: prdata = kmcr_pkg::APB_DATA_W'(cfg.key_lock);
      default:                prdata = '0;
    endcase
  end

endmodule

[rtl/core/kmcr_keymap.sv]
// ----------------------------------------------------------------------------
// kmcr_keymap
// Keymap memory, one write and one registered read a cycle; per-entry valid
// flops make unwritten entries read as unmapped after reset.
// ----------------------------------------------------------------------------
module kmcr_keymap #(
  parameter int KEYMAP_DEPTH = kmcr_pkg::DEF_KEYMAP_DEPTH
) (
  input  logic                              clk,
  input  logic                              rst,
  input  kmcr_pkg::kmcr_km_req_t            req,
  output logic [kmcr_pkg::KEY_CODE_W-1:0]   rdata
);

  localparam int AW = (KEYMAP_DEPTH > 1) ? $clog2(KEYMAP_DEPTH) : 1;

  logic [kmcr_pkg::KEY_CODE_W-1:0] mem [KEYMAP_DEPTH];
  logic [KEYMAP_DEPTH-1:0]         entry_valid;
  logic [kmcr_pkg::KEY_CODE_W-1:0] rdata_q;
  logic                            rvalid_q;

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr[AW-1:0]] <= req.wdata;
    end
    if (req.re) begin
      rdata_q <= mem[req.raddr[AW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      entry_valid <= '0;
      rvalid_q    <= 1'b0;
    end else begin
      if (req.we) begin
        entry_valid[req.waddr[AW-1:0]] <= 1'b1;
      end
      if (req.re) begin
        rvalid_q <= entry_valid[req.raddr[AW-1:0]];
      end
    end
  end

  assign rdata = rvalid_q ? rdata_q : '0;

endmodule

[rtl/core/kmcr_scan.sv]
// ----------------------------------------------------------------------------
// kmcr_scan
// Item intake and change scan: walks columns and rows, unless locked looks up
// changed positions in the keymap and loads events into the output register.
// ----------------------------------------------------------------------------
module kmcr_scan #(
  parameter int MAX_COLUMNS  = kmcr_pkg::DEF_MAX_COLUMNS,
  parameter int MAX_ROWS     = kmcr_pkg::DEF_MAX_ROWS,
  parameter int KEYMAP_DEPTH = kmcr_pkg::DEF_KEYMAP_DEPTH
) (
  input  logic                              clk,
  input  logic                              rst,
  input  kmcr_pkg::kmcr_cfg_t               cfg,
  kmcr_in_if.sink                           items,
  kmcr_out_if.source                        events,
  output kmcr_pkg::kmcr_km_req_t            km_req,
  input  logic [kmcr_pkg::KEY_CODE_W-1:0]   km_rdata
);

  localparam int CW  = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1;
  localparam int RW  = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int SCW = kmcr_pkg::SCAN_CODE_W;
  localparam int IXW = $clog2(kmcr_pkg::SNAP_W);

  typedef enum logic [1:0] {IDLE, LOOK, EVAL, SYNC} state_t;

  state_t                        state;
  logic [kmcr_pkg::SNAP_W-1:0]   snap_q;
  logic [kmcr_pkg::SNAP_W-1:0]   prev_q;
  logic [CW-1:0]                 col;
  logic [RW-1:0]                 row;

  logic [kmcr_pkg::COUNT_W-1:0]  rows_eff;
  logic [kmcr_pkg::COUNT_W-1:0]  cols_eff;
  logic [kmcr_pkg::SHIFT_W-1:0]  shift;
  logic [IXW-1:0]                bit_idx;
  logic [SCW-1:0]                code;
  logic                          in_range;
  logic                          changed;
  logic                          row_last;
  logic                          col_last;
  logic                          slot_free;
  logic                          accept;
  logic                          load_event;
  logic                          load_sync;

  assign rows_eff = (cfg.rows_in_use > kmcr_pkg::COUNT_W'(MAX_ROWS)) ?
                    kmcr_pkg::COUNT_W'(MAX_ROWS) : cfg.rows_in_use;
  assign cols_eff = (cfg.columns_in_use > kmcr_pkg::COUNT_W'(MAX_COLUMNS)) ?
                    kmcr_pkg::COUNT_W'(MAX_COLUMNS) : cfg.columns_in_use;
  assign shift    = kmcr_pkg::order_of(cols_eff);

  assign bit_idx  = (IXW'(col) << kmcr_pkg::ROW_BITS) | IXW'(row);
  assign code     = SCW'(SCW'(row) << shift) + SCW'(col);
  assign in_range = {1'b0, code} < (SCW + 1)'(KEYMAP_DEPTH);
  assign changed  = snap_q[bit_idx] ^ prev_q[bit_idx];
  assign row_last = (kmcr_pkg::COUNT_W'(row) + 4'd1) == rows_eff;
  assign col_last = (kmcr_pkg::COUNT_W'(col) + 4'd1) == cols_eff;

  assign slot_free   = !events.valid || events.ready;
  assign items.ready = (state == IDLE);
  assign accept      = items.valid && items.ready;

  // output register is reloaded this cycle
  assign load_event = (state == EVAL) && (km_rdata != '0) && slot_free;
  assign load_sync  = (state == SYNC) && slot_free;

  always_comb begin
    km_req.we    = accept && (items.cmd == kmcr_pkg::CMD_MAP_WRITE) &&
                   ({1'b0, items.map_index} < (SCW + 1)'(KEYMAP_DEPTH));
    km_req.waddr = items.map_index;
    km_req.wdata = items.map_keycode;
    km_req.re    = (state == LOOK) && changed && !cfg.key_lock && in_range;
    km_req.raddr = code;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= IDLE;
      prev_q       <= '0;
      col          <= '0;
      row          <= '0;
      events.valid <= 1'b0;
    end else begin
      if (events.valid && events.ready && !load_event && !load_sync) begin
        events.valid <= 1'b0;
      end
      unique case (state)
        IDLE: begin
          if (accept && items.cmd == kmcr_pkg::CMD_SNAPSHOT) begin
            snap_q <= items.matrix_snapshot;
            col    <= '0;
            row    <= '0;
            if (rows_eff == '0 || cols_eff == '0) begin
              state <= SYNC;
            end else begin
              state <= LOOK;
            end
          end
        end
        LOOK: begin
          if (km_req.re) begin
            state <= EVAL;
          end else if (!row_last) begin
            row <= row + 1'b1;
          end else if (!col_last) begin
            row <= '0;
            col <= col + 1'b1;
          end else begin
            state <= SYNC;
          end
        end
        EVAL: begin
          if (km_rdata != '0) begin
            if (slot_free) begin
              events.valid     <= 1'b1;
              events.scan_code <= code;
              events.key_code  <= km_rdata;
              events.pressed   <= snap_q[bit_idx];
              events.is_sync   <= 1'b0;
              events.last      <= 1'b0;
              row              <= '0;
              if (col_last) begin
                state <= SYNC;
              end else begin
                col   <= col + 1'b1;
                state <= LOOK;
              end
            end
          end else if (!row_last) begin
            row   <= row + 1'b1;
            state <= LOOK;
          end else if (!col_last) begin
            row   <= '0;
            col   <= col + 1'b1;
            state <= LOOK;
          end else begin
            state <= SYNC;
          end
        end
        SYNC: begin
          if (slot_free) begin
            events.valid     <= 1'b1;
            events.scan_code <= '0;
            events.key_code  <= '0;
            events.pressed   <= 1'b0;
            events.is_sync   <= 1'b1;
            events.last      <= 1'b1;
            prev_q           <= snap_q;
            state            <= IDLE;
          end
        end
        default: state <= IDLE;
      endcase
    end
  end

endmodule

[verif/testbench.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Checks the keypad matrix change reporter against a behavioural predictor
// of the scan. Snapshots and keymap writes go in over the item channel and
// the reported key events and sync markers are compared field by field, in
// order. The scan settings are swept over APB and read back, and both sides
// of the data path idle and stall at random.
// ----------------------------------------------------------------------------
module testbench;

  localparam int WATCHDOG_LIMIT = 4000;
  localparam int SETTLE_CYCLES  = 16;
  localparam int END_CYCLES     = 150;
  localparam int HOLD_CYCLES    = 300;
  localparam int PHASE_ITEMS    = 22;

  typedef struct packed {
    logic [kmcr_pkg::SCAN_CODE_W-1:0] scan_code;
    logic [kmcr_pkg::KEY_CODE_W-1:0]  key_code;
    logic                             pressed;
    logic                             is_sync;
    logic                             last;
  } key_event_t;

  logic clk;
  logic rst;
  logic psel;
  logic penable;
  logic pwrite;
  logic [kmcr_pkg::APB_ADDR_W-1:0] paddr;
  logic [kmcr_pkg::APB_DATA_W-1:0] pwdata;
  logic [kmcr_pkg::APB_DATA_W-1:0] prdata;
  logic pready;

  kmcr_in_if  items_ch ();
  kmcr_out_if events_ch ();

  keypad_matrix_change_reporter dut (
    .clk     (clk),
    .rst     (rst),
    .items   (items_ch),
    .events  (events_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // predictor state
  logic [kmcr_pkg::COUNT_W-1:0]    cfg_rows;
  logic [kmcr_pkg::COUNT_W-1:0]    cfg_cols;
  logic                            cfg_lock;
  logic [kmcr_pkg::SNAP_W-1:0]     stored_matrix;
  logic [kmcr_pkg::KEY_CODE_W-1:0] keymap_shadow [kmcr_pkg::DEF_KEYMAP_DEPTH];
  key_event_t                      expected_events [$];

  int  error_count;
  int  snapshots_sent;
  int  map_writes_sent;
  int  events_checked;
  int  syncs_checked;
  int  settings_applied;
  int  idle_cycles;
  int  hold_left;
  int  hold_requests;
  int  holds_served;
  int  stall_left;
  bit  sender_gaps;
  bit  receiver_stalls;

  always begin
    clk = 1'b1;
    #2;
    clk = 1'b0;
    #2;
  end

  task automatic note_mismatch(string msg);
    error_count++;
    $display("mismatch at %0t: %s", $realtime, msg);
  endtask

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic void predict_snapshot(logic [kmcr_pkg::SNAP_W-1:0] snap);
    int n_rows;
    int n_cols;
    int shift;
    int code;
    logic [7:0] changed;
    logic [kmcr_pkg::KEY_CODE_W-1:0] kc;
    key_event_t ev;
    n_rows = (cfg_rows > kmcr_pkg::DEF_MAX_ROWS) ? kmcr_pkg::DEF_MAX_ROWS : cfg_rows;
    n_cols = (cfg_cols > kmcr_pkg::DEF_MAX_COLUMNS) ? kmcr_pkg::DEF_MAX_COLUMNS : cfg_cols;
    shift = 0;
    while (shift < 4 && (1 << shift) < n_cols) shift++;
    for (int c = 0; c < n_cols; c++) begin
      changed = snap[8*c +: 8] ^ stored_matrix[8*c +: 8];
      for (int r = 0; r < n_rows; r++) begin
        if (changed[r]) begin
          code = (r << shift) + c;
          kc = (code < kmcr_pkg::DEF_KEYMAP_DEPTH) ? keymap_shadow[code] : '0;
          if (kc != 0 && !cfg_lock) begin
            ev.scan_code = code[kmcr_pkg::SCAN_CODE_W-1:0];
            ev.key_code  = kc;
            ev.pressed   = snap[8*c + r];
            ev.is_sync   = 1'b0;
            ev.last      = 1'b0;
            expected_events.push_back(ev);
            break;
          end
        end
      end
    end
    ev = '0;
    ev.is_sync = 1'b1;
    ev.last    = 1'b1;
    expected_events.push_back(ev);
    stored_matrix = snap;
  endfunction

  task automatic send_item(logic cmd, logic [kmcr_pkg::SNAP_W-1:0] snap,
                           logic [kmcr_pkg::SCAN_CODE_W-1:0] idx,
                           logic [kmcr_pkg::KEY_CODE_W-1:0] kc);
    int gap;
    gap = sender_gaps ? pick_gap() : 0;
    if (gap > 0) begin
      items_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    items_ch.valid           <= 1'b1;
    items_ch.cmd             <= cmd;
    items_ch.matrix_snapshot <= snap;
    items_ch.map_index       <= idx;
    items_ch.map_keycode     <= kc;
    do @(posedge clk); while (!items_ch.ready);
    if (cmd == kmcr_pkg::CMD_MAP_WRITE) begin
      keymap_shadow[idx] = kc;
      map_writes_sent++;
    end else begin
      predict_snapshot(snap);
      snapshots_sent++;
    end
  endtask

  task automatic send_snapshot(logic [kmcr_pkg::SNAP_W-1:0] snap);
    send_item(kmcr_pkg::CMD_SNAPSHOT, snap,
              kmcr_pkg::SCAN_CODE_W'($urandom_range(0, 63)),
              kmcr_pkg::KEY_CODE_W'($urandom_range(0, 1023)));
  endtask

  task automatic send_map_write(logic [kmcr_pkg::SCAN_CODE_W-1:0] idx,
                                logic [kmcr_pkg::KEY_CODE_W-1:0] kc);
    send_item(kmcr_pkg::CMD_MAP_WRITE, {$urandom, $urandom}, idx, kc);
  endtask

  task automatic wait_for_drain(int settle);
    items_ch.valid <= 1'b0;
    while (expected_events.size() != 0) @(posedge clk);
    repeat (settle) @(posedge clk);
  endtask

  task automatic write_register(logic [1:0] index, logic [kmcr_pkg::APB_DATA_W-1:0] value);
    logic [kmcr_pkg::APB_DATA_W-1:0] mask;
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {index, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    case (index)
      kmcr_pkg::REG_ROWS:     cfg_rows = value[kmcr_pkg::COUNT_W-1:0];
      kmcr_pkg::REG_COLUMNS:  cfg_cols = value[kmcr_pkg::COUNT_W-1:0];
      kmcr_pkg::REG_KEY_LOCK: cfg_lock = value[0];
      default: ;
    endcase
    // back-to-back read of the same register
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    mask = (index == kmcr_pkg::REG_KEY_LOCK) ? 32'h1 : 32'hF;
    if ((prdata & mask) !== (value & mask))
      note_mismatch($sformatf("register %0d read %h, wrote %h", index, prdata, value));
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic apply_setting(logic [kmcr_pkg::COUNT_W-1:0] rows,
                               logic [kmcr_pkg::COUNT_W-1:0] cols, logic lock);
    logic [kmcr_pkg::APB_DATA_W-1:0] junk;
    wait_for_drain(SETTLE_CYCLES);
    junk = ($urandom_range(0, 3) == 0) ? $urandom : '0;
    write_register(kmcr_pkg::REG_ROWS,
                   {junk[kmcr_pkg::APB_DATA_W-1:kmcr_pkg::COUNT_W], rows});
    junk = ($urandom_range(0, 3) == 0) ? $urandom : '0;
    write_register(kmcr_pkg::REG_COLUMNS,
                   {junk[kmcr_pkg::APB_DATA_W-1:kmcr_pkg::COUNT_W], cols});
    junk = ($urandom_range(0, 3) == 0) ? $urandom : '0;
    write_register(kmcr_pkg::REG_KEY_LOCK, {junk[kmcr_pkg::APB_DATA_W-1:1], lock});
    settings_applied++;
  endtask

  function automatic logic [kmcr_pkg::SNAP_W-1:0] next_snapshot();
    logic [kmcr_pkg::SNAP_W-1:0] snap;
    int n_cols;
    int r;
    int flips;
    snap = stored_matrix;
    n_cols = (cfg_cols > kmcr_pkg::DEF_MAX_COLUMNS) ? kmcr_pkg::DEF_MAX_COLUMNS : cfg_cols;
    r = $urandom_range(0, 99);
    if (r < 55) begin
      flips = $urandom_range(1, 3);
      repeat (flips) begin
        if (n_cols > 0 && $urandom_range(0, 4) != 0)
          snap[8*$urandom_range(0, n_cols-1) + $urandom_range(0, 7)] ^= 1'b1;
        else
          snap[$urandom_range(0, kmcr_pkg::SNAP_W-1)] ^= 1'b1;
      end
    end else if (r < 70) begin
      snap[8*$urandom_range(0, 7) +: 8] ^= 8'($urandom_range(1, 255));
    end else if (r < 82) begin
      snap = {$urandom, $urandom};
    end else if (r < 92) begin
      snap = stored_matrix;
    end else begin
      snap = $urandom_range(0, 1) ? '1 : '0;
    end
    return snap;
  endfunction

  task automatic send_random_item();
    int r;
    logic [kmcr_pkg::KEY_CODE_W-1:0] kc;
    if ($urandom_range(0, 99) < 12) begin
      r = $urandom_range(0, 99);
      kc = (r < 15) ? '0 : (r < 25) ? '1 :
           kmcr_pkg::KEY_CODE_W'($urandom_range(1, 1023));
      send_map_write(kmcr_pkg::SCAN_CODE_W'($urandom_range(0, 63)), kc);
    end else begin
      send_snapshot(next_snapshot());
    end
  endtask

  // result checking
  always @(posedge clk) begin
    key_event_t want;
    if (!rst && events_ch.valid && events_ch.ready) begin
      if (expected_events.size() == 0) begin
        note_mismatch($sformatf("transaction with nothing expected: code %0d sync %b",
                                events_ch.scan_code, events_ch.is_sync));
      end else begin
        want = expected_events.pop_front();
        if (events_ch.scan_code !== want.scan_code)
          note_mismatch($sformatf("scan_code %0d, want %0d", events_ch.scan_code,
                                  want.scan_code));
        if (events_ch.key_code !== want.key_code)
          note_mismatch($sformatf("key_code %0d, want %0d", events_ch.key_code,
                                  want.key_code));
        if (events_ch.pressed !== want.pressed)
          note_mismatch($sformatf("pressed %b, want %b", events_ch.pressed, want.pressed));
        if (events_ch.is_sync !== want.is_sync)
          note_mismatch($sformatf("is_sync %b, want %b", events_ch.is_sync, want.is_sync));
        if (events_ch.last !== want.last)
          note_mismatch($sformatf("last %b, want %b", events_ch.last, want.last));
        if (want.is_sync) syncs_checked++;
        else events_checked++;
      end
    end
  end

  // receiver: long hold-off on request, otherwise random stalls if receiver_stalls is set
  always @(posedge clk) begin
    if (rst) begin
      events_ch.ready <= 1'b0;
    end else if (hold_requests != holds_served) begin
      events_ch.ready <= 1'b0;
      hold_left <= HOLD_CYCLES;
      holds_served <= hold_requests;
    end else if (hold_left > 0) begin
      events_ch.ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (!receiver_stalls) begin
      events_ch.ready <= 1'b1;
    end else if (stall_left > 0) begin
      events_ch.ready <= 1'b0;
      stall_left <= stall_left - 1;
    end else if ($urandom_range(0, 3) == 0) begin
      events_ch.ready <= 1'b0;
      stall_left <= pick_gap();
    end else begin
      events_ch.ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (rst || (items_ch.valid && items_ch.ready) || (events_ch.valid && events_ch.ready)
        || (psel && penable && pready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("watchdog: no transaction for %0d cycles, %0d results outstanding",
                 idle_cycles, expected_events.size());
        $display("RESULT: ERROR");
        $finish;
      end
    end
  end

  task automatic test_reset_and_keymap();
    sender_gaps = 1'b0;
    receiver_stalls = 1'b0;
    send_snapshot(64'h1);                     // unmapped key
    send_map_write(6'd0, 10'd1023);
    send_map_write(6'd63, 10'd1);
    send_map_write(6'd9, 10'h2AA);
    send_map_write(6'd8, 10'h155);
    send_item(kmcr_pkg::CMD_SNAPSHOT, 64'h0, 6'd5, 10'd77);
    send_snapshot(64'h3);                     // two mapped changes, one column
    send_snapshot('1);
    send_snapshot('1);                        // no change
    send_snapshot('0);
    send_map_write(6'd63, 10'd0);
    send_snapshot(64'h8000_0000_0000_0000);   // unmapped again
    send_snapshot('0);
  endtask

  task automatic test_setting_sweep();
    int rows_list [10] = '{8, 1, 15, 0, 4, 3, 8, 2, 9, 8};
    int cols_list [10] = '{8, 1, 12, 5, 0, 3, 8, 2, 8, 15};
    bit lock_list [10] = '{0, 0, 0, 0, 0, 0, 1, 0, 0, 0};
    for (int i = 0; i < 32; i++)
      send_map_write(kmcr_pkg::SCAN_CODE_W'($urandom_range(0, 63)),
                     kmcr_pkg::KEY_CODE_W'($urandom_range(1, 1023)));
    for (int p = 0; p < 13; p++) begin
      if (p < 10)
        apply_setting(kmcr_pkg::COUNT_W'(rows_list[p]), kmcr_pkg::COUNT_W'(cols_list[p]),
                      lock_list[p]);
      else
        apply_setting(kmcr_pkg::COUNT_W'($urandom_range(0, 15)),
                      kmcr_pkg::COUNT_W'($urandom_range(0, 15)),
                      $urandom_range(0, 3) == 0);
      sender_gaps = $urandom_range(0, 3) != 0;
      receiver_stalls = $urandom_range(0, 3) != 0;
      repeat (PHASE_ITEMS) send_random_item();
    end
  endtask

  task automatic test_output_backpressure();
    apply_setting(4'd8, 4'd8, 1'b0);
    sender_gaps = 1'b0;
    receiver_stalls = 1'b0;
    hold_requests++;
    repeat (20) send_snapshot({$urandom, $urandom});
  endtask

  task automatic test_pause_until_drained();
    sender_gaps = 1'b1;
    receiver_stalls = 1'b1;
    repeat (5) send_random_item();
    wait_for_drain(0);
    repeat (5) send_random_item();
  endtask

  initial begin
    rst = 1'b1;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    items_ch.valid = 1'b0;
    items_ch.cmd = kmcr_pkg::CMD_SNAPSHOT;
    items_ch.matrix_snapshot = '0;
    items_ch.map_index = '0;
    items_ch.map_keycode = '0;
    sender_gaps = 1'b0;
    receiver_stalls = 1'b0;
    cfg_rows = kmcr_pkg::ROWS_RESET;
    cfg_cols = kmcr_pkg::COLUMNS_RESET;
    cfg_lock = 1'b0;
    stored_matrix = '0;
    foreach (keymap_shadow[i]) keymap_shadow[i] = '0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    test_reset_and_keymap();
    test_setting_sweep();
    test_output_backpressure();
    test_pause_until_drained();

    wait_for_drain(END_CYCLES);
    $display("covered %0d snapshots and %0d keymap writes over %0d scan settings",
             snapshots_sent, map_writes_sent, settings_applied);
    $display("checked %0d key events and %0d sync transactions, %0d mismatches",
             events_checked, syncs_checked, error_count);
    if (error_count == 0 && expected_events.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
